### hdl/bsm_pkg.sv
// Package for the bipartite slot matcher: sizes, beat payload structs,
// stack frame type and the command/status structs between controller and datapath.
// No dependencies.
package bsm_pkg;

	localparam int MAX_SLOTS   = 16;
	localparam int MAX_CLAIMS  = 16;
	localparam int ROW_W       = 16;
	localparam int CLAIM_LIMIT = (MAX_CLAIMS < ROW_W) ? MAX_CLAIMS : ROW_W;
	localparam int STACK_DEPTH = MAX_SLOTS + 1;

	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int CLAIM_W   = (CLAIM_LIMIT > 1) ? $clog2(CLAIM_LIMIT) : 1;
	localparam int NEXT_W    = $clog2(CLAIM_LIMIT + 1);
	localparam int STK_IDX_W = $clog2(STACK_DEPTH);
	localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
	localparam int MIN_W     = 5;
	localparam int OUT_CNT_W = 5;

	typedef struct packed {
		logic [ROW_W-1:0] slot_candidates;
		logic             last_slot;
	} bsm_in_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] matched_count;
		logic                 match_ok;
		logic                 too_many_slots;
	} bsm_out_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [NEXT_W-1:0] next;
	} bsm_frame_t;

	typedef struct packed {
		logic load;
		logic init;
		logic root;
		logic search;
		logic wb;
		logic finish;
	} bsm_cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic depth_last;
		logic root_last;
		logic empty;
	} bsm_sts_t;

endpackage

### hdl/bsm_datapath.sv
// Datapath of the slot matcher: row store, search stack, claim owners, masks.
// Executes one command per cycle from bsm_ctrl; depends on bsm_pkg.
module bsm_datapath import bsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bsm_cmd_t         cmd,
	output bsm_sts_t         sts,
	input  bsm_in_t          slot_in,
	input  logic             cfg_we,
	input  logic [MIN_W-1:0] cfg_data,
	output bsm_out_t         result
);

	logic [ROW_W-1:0]       rows_q  [MAX_SLOTS];
	bsm_frame_t             stack_q [STACK_DEPTH];
	logic [SLOT_W-1:0]      owner_q [CLAIM_LIMIT];

	logic [CNT_W-1:0]       slot_count_q;
	logic                   overflow_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [SLOT_W-1:0]      root_q;
	logic [CNT_W-1:0]       matched_q;
	logic [CLAIM_LIMIT-1:0] owned_q;
	logic [CLAIM_LIMIT-1:0] visited_q;
	logic [MIN_W-1:0]       min_q;

	logic [STK_IDX_W-1:0]   top_idx;
	logic [STK_IDX_W-1:0]   push_idx;
	bsm_frame_t             top;
	logic [ROW_W-1:0]       row;
	logic [CLAIM_LIMIT-1:0] avail;
	logic [CLAIM_W-1:0]     sel;
	logic [CLAIM_W-1:0]     wb_claim;
	logic                   can_push;

	assign top_idx  = STK_IDX_W'(depth_q - DEPTH_W'(1));
	assign push_idx = STK_IDX_W'(depth_q);
	assign top      = stack_q[top_idx];
	assign row      = rows_q[top.slot];
	assign wb_claim = CLAIM_W'(top.next - NEXT_W'(1));
	assign can_push = depth_q < DEPTH_W'(STACK_DEPTH);

	always_comb begin
		for (int k = 0; k < CLAIM_LIMIT; k++) begin
			avail[k] = row[k] & ~visited_q[k] & (NEXT_W'(k) >= top.next);
		end
		sel = '0;
		for (int k = CLAIM_LIMIT - 1; k >= 0; k--) begin
			if (avail[k]) begin
				sel = CLAIM_W'(k);
			end
		end
	end

	assign sts.hit        = |avail;
	assign sts.free       = ~owned_q[sel];
	assign sts.depth_last = (depth_q == DEPTH_W'(1));
	assign sts.root_last  = (CNT_W'(root_q) + CNT_W'(1) == slot_count_q);
	assign sts.empty      = (slot_count_q == '0);

	assign result.matched_count  = OUT_CNT_W'(matched_q);
	assign result.match_ok       = (OUT_CNT_W'(matched_q) >= OUT_CNT_W'(min_q));
	assign result.too_many_slots = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			overflow_q   <= 1'b0;
			depth_q      <= '0;
			root_q       <= '0;
			matched_q    <= '0;
			owned_q      <= '0;
			visited_q    <= '0;
			min_q        <= MIN_W'(1);
		end else begin
			if (cfg_we) begin
				min_q <= cfg_data;
			end
			if (cmd.load) begin
				if (slot_count_q < CNT_W'(MAX_SLOTS)) begin
					slot_count_q <= slot_count_q + CNT_W'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				owned_q   <= '0;
				matched_q <= '0;
				root_q    <= '0;
			end
			if (cmd.root) begin
				depth_q   <= DEPTH_W'(1);
				visited_q <= '0;
			end
			if (cmd.search) begin
				if (sts.hit) begin
					visited_q[sel] <= 1'b1;
					if (!sts.free && can_push) begin
						depth_q <= depth_q + DEPTH_W'(1);
					end
				end else begin
					depth_q <= depth_q - DEPTH_W'(1);
					if (sts.depth_last) begin
						root_q <= root_q + SLOT_W'(1);
					end
				end
			end
			if (cmd.wb) begin
				owned_q[wb_claim] <= 1'b1;
				depth_q           <= depth_q - DEPTH_W'(1);
				if (sts.depth_last) begin
					matched_q <= matched_q + CNT_W'(1);
					root_q    <= root_q + SLOT_W'(1);
				end
			end
			if (cmd.finish) begin
				slot_count_q <= '0;
				overflow_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && slot_count_q < CNT_W'(MAX_SLOTS)) begin
			rows_q[SLOT_W'(slot_count_q)] <= slot_in.slot_candidates;
		end
		if (cmd.root) begin
			stack_q[0] <= '{slot: root_q, next: '0};
		end
		if (cmd.search && sts.hit) begin
			stack_q[top_idx].next <= NEXT_W'(sel) + NEXT_W'(1);
			if (!sts.free && can_push) begin
				stack_q[push_idx] <= '{slot: owner_q[sel], next: '0};
			end
		end
		if (cmd.wb) begin
			owner_q[wb_claim] <= top.slot;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("search stack depth out of range");

	a_search_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> depth_q != '0)
		else $error("search step with empty stack");

	a_wb_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> depth_q != '0)
		else $error("writeback step with empty stack");

endmodule

### hdl/bsm_ctrl.sv
// Controller state machine of the slot matcher: row loading, augmenting-path
// search sequencing and result strobe. Depends on bsm_pkg.
module bsm_ctrl import bsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     last_slot,
	input  bsm_sts_t sts,
	output bsm_cmd_t cmd,
	output logic     busy,
	output logic     result_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROOT,
		ST_SEARCH,
		ST_WB,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   valid_q;

	assign busy         = busy_q;
	assign result_valid = valid_q;

	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.init   = (state_q == ST_INIT);
	assign cmd.root   = (state_q == ST_ROOT);
	assign cmd.search = (state_q == ST_SEARCH);
	assign cmd.wb     = (state_q == ST_WB);
	assign cmd.finish = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && last_slot) begin
						state_q <= ST_INIT;
						busy_q  <= 1'b1;
					end
				end
				ST_INIT: begin
					if (sts.empty) begin
						state_q <= ST_DONE;
						valid_q <= 1'b1;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (sts.hit) begin
						if (sts.free) begin
							state_q <= ST_WB;
						end
					end else if (sts.depth_last) begin
						if (sts.root_last) begin
							state_q <= ST_DONE;
							valid_q <= 1'b1;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_WB: begin
					if (sts.depth_last) begin
						if (sts.root_last) begin
							state_q <= ST_DONE;
							valid_q <= 1'b1;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					valid_q <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("busy still set after result beat");

	a_row_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_slot |=> !busy && !result_valid)
		else $error("non-final row left idle");

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat outside a run");

endmodule

### hdl/bipartite_slot_matcher.sv
// Top level of the bipartite slot matcher: controller plus datapath.
// Depends on bsm_pkg, bsm_ctrl, bsm_datapath.
//
// Rows are taken one per cycle while busy is low; a row without last_slot
// is stored and busy stays low. Rows past MAX_SLOTS are dropped and reported
// as too_many_slots. The row with last_slot starts the matching: busy rises
// and a setup step (ST_INIT) follows, then for each stored slot a root setup
// step (ST_ROOT), search steps that each try a claim or pop a frame, and a
// writeback step per frame of an augmenting path (ST_WB). The search runs
// one step per cycle through the shared stack and owner table. The result
// appears on result for exactly one cycle with result_valid high; it cannot
// be held off, so the receiver must take it then. busy falls in the cycle
// after the result beat.
module bipartite_slot_matcher import bsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bsm_in_t          slot_in,
	output logic             result_valid,
	output bsm_out_t         result,
	input  logic             cfg_we,
	input  logic [MIN_W-1:0] cfg_data
);

	bsm_cmd_t cmd;
	bsm_sts_t sts;

	bsm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_slot    (slot_in.last_slot),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	bsm_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.slot_in  (slot_in),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule
